// File: design/cba_pkg.sv
// Shared codes and field widths of the chunked bitmap slot allocator.
// No dependencies; the interfaces, the allocator and the testbench take names from here.
package cba_pkg;

	// field widths of the request and response words
	localparam int FUNC_W   = 2;
	localparam int HANDLE_W = 15;
	localparam int STATUS_W = 2;
	localparam int CIDX_W   = 6;
	localparam int OFFS_W   = 24;
	localparam int ACTIVE_W = 7;

	// configuration register widths and indexes
	localparam int CB_W    = 6;
	localparam int MINC_W  = 7;
	localparam int ESIZE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINIMAL_CHUNKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE      = 2'd2;

	localparam logic [CB_W-1:0]    CHUNK_BYTES_RST = 6'd4;
	localparam logic [MINC_W-1:0]  MIN_CHUNKS_RST  = 7'd4;
	localparam logic [ESIZE_W-1:0] ESIZE_RST       = 16'd1;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd3;

	localparam logic [7:0] BYTE_FULL = 8'hFF;

endpackage

// File: design/cba_ifs.sv
// Request and response channel interfaces of the slot allocator.
// Depends on cba_pkg for the field widths.
interface cba_req_if;
	logic                          valid;
	logic                          ready;
	logic [cba_pkg::FUNC_W-1:0]    func;
	logic [cba_pkg::HANDLE_W-1:0]  handle;
	modport source (output valid, func, handle, input ready);
	modport sink (input valid, func, handle, output ready);
endinterface

interface cba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cba_pkg::STATUS_W-1:0]  status;
	logic [cba_pkg::HANDLE_W-1:0]  new_handle;
	logic [cba_pkg::CIDX_W-1:0]    chunk_num;
	logic [cba_pkg::OFFS_W-1:0]    byte_offset;
	logic [cba_pkg::ACTIVE_W-1:0]  active_chunks;
	modport source (output valid, status, new_handle, chunk_num, byte_offset,
		active_chunks, input ready);
	modport sink (input valid, status, new_handle, chunk_num, byte_offset,
		active_chunks, output ready);
endinterface

// File: design/chunked_bitmap_slot_allocator.sv
// Chunked bitmap slot allocator: hands out, frees and looks up 1-based slot
// handles over a list of chunks whose occupancy bits sit in one byte store.
// Channels: req (func, handle) and rsp (status, new_handle, chunk_num,
// byte_offset, active_chunks), valid/ready, one response word per request.
// Config: cfg_we/cfg_index/cfg_data write chunk_bytes, minimal_chunks and
// slot size; any write to a listed register restarts the clearing pass.
// Working: every byte of the store visited takes a read state and a check
// state, as the single store port serves one access a cycle. Allocate scans
// bytes from the bottom up; free and lookup first split the handle, one
// chunk at a time, then read and check its byte; free then clears the bit
// and runs the trim scan, which reads the bytes of the top chunk and drops
// empty chunks from the top down to the minimum.
// One request is worked at a time; the next is taken in the idle state after the load.
// Reset: the store is cleared one byte a cycle over all its entries (2048 by
// default, MAX_CHUNKS*MAX_CHUNK_BYTES rounded up to a power of two in depth)
// before the first request is taken, and again after any listed config write.
// Stall: the response word waits in an output register; a further request
// is taken and worked, and its result waits until that register is free.
module chunked_bitmap_slot_allocator #(
	parameter int MAX_CHUNKS      = 64,
	parameter int MAX_CHUNK_BYTES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cba_req_if.sink                         req,
	cba_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [cba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cba_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int NW  = $clog2(MAX_CHUNKS + 1);
	localparam int BW  = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
	localparam int BNW = $clog2(MAX_CHUNK_BYTES + 1);
	localparam int AW  = CW + BW;
	localparam int SW  = CW + BW + 4;
	localparam int RW  = cba_pkg::HANDLE_W - 3;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ARD  = 4'd2;
	localparam logic [3:0] S_ACHK = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_HRD  = 4'd5;
	localparam logic [3:0] S_HCHK = 4'd6;
	localparam logic [3:0] S_TST  = 4'd7;
	localparam logic [3:0] S_TRD  = 4'd8;
	localparam logic [3:0] S_TCHK = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]                        state_q;
	logic [AW-1:0]                     clr_q;
	logic [cba_pkg::CB_W-1:0]          cb_q;
	logic [cba_pkg::MINC_W-1:0]        minc_q;
	logic [cba_pkg::ESIZE_W-1:0]       es_q;
	logic [NW-1:0]                     total_q;
	logic [cba_pkg::FUNC_W-1:0]        func_q;
	logic [CW-1:0]                     c_q;
	logic [BW-1:0]                     b_q;
	logic [SW-1:0]                     base_q;
	logic [RW-1:0]                     rem_q;
	logic [2:0]                        k_q;
	logic [cba_pkg::STATUS_W-1:0]      st_q;
	logic [cba_pkg::HANDLE_W-1:0]      nh_q;
	logic [CW-1:0]                     ci_q;
	logic [cba_pkg::OFFS_W-1:0]        off_q;
	logic                              rsp_valid_q;
	logic [cba_pkg::STATUS_W-1:0]      rsp_status_q;
	logic [cba_pkg::HANDLE_W-1:0]      rsp_nh_q;
	logic [cba_pkg::CIDX_W-1:0]        rsp_ci_q;
	logic [cba_pkg::OFFS_W-1:0]        rsp_off_q;
	logic [cba_pkg::ACTIVE_W-1:0]      rsp_act_q;

	logic [BNW-1:0]                    bpc;
	logic [NW-1:0]                     eff_min;
	logic                              mem_we;
	logic [AW-1:0]                     mem_addr;
	logic [7:0]                        mem_wdata;
	logic [7:0]                        mem_rdata;
	logic [2:0]                        zero_k;
	logic                              last_b;
	logic                              last_c;
	logic [cba_pkg::HANDLE_W-1:0]      idx;
	logic [CW-1:0]                     top_c;
	logic                              slot_free;

	// effective chunk size and minimum
	always_comb begin
		if (cb_q == '0) begin
			bpc = BNW'(1);
		end else if (32'(cb_q) > MAX_CHUNK_BYTES) begin
			bpc = BNW'(MAX_CHUNK_BYTES);
		end else begin
			bpc = BNW'(cb_q);
		end
		if (minc_q == '0) begin
			eff_min = NW'(1);
		end else if (32'(minc_q) > MAX_CHUNKS) begin
			eff_min = NW'(MAX_CHUNKS);
		end else begin
			eff_min = NW'(minc_q);
		end
	end

	// lowest clear bit of the byte read back
	always_comb begin
		zero_k = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!mem_rdata[i]) begin
				zero_k = 3'(i);
			end
		end
	end

	assign last_b    = (32'(b_q) + 1) == 32'(bpc);
	assign last_c    = (32'(c_q) + 1) >= 32'(total_q);
	assign idx       = req.handle - cba_pkg::HANDLE_W'(1);
	assign top_c     = CW'(total_q - NW'(1));
	assign slot_free = !mem_rdata[k_q];

	// store access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = {c_q, b_q};
		mem_wdata = 8'd0;
		unique case (state_q)
			S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_ACHK: begin
				if (mem_rdata != cba_pkg::BYTE_FULL) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata | (8'd1 << zero_k);
				end else if (last_b && last_c && 32'(total_q) < MAX_CHUNKS) begin
					mem_we    = 1'b1;
					mem_addr  = {CW'(total_q), BW'(0)};
					mem_wdata = 8'd1;
				end
			end
			S_HRD: mem_addr = {c_q, BW'(rem_q)};
			S_HCHK: begin
				mem_addr = {c_q, BW'(rem_q)};
				if (func_q == cba_pkg::FUNC_FREE) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata & ~(8'd1 << k_q);
				end
			end
			S_TRD: mem_addr = {top_c, b_q};
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	cba_bitmap_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q   <= cba_pkg::CHUNK_BYTES_RST;
			minc_q <= cba_pkg::MIN_CHUNKS_RST;
			es_q   <= cba_pkg::ESIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cba_pkg::REG_CHUNK_BYTES:    cb_q   <= cba_pkg::CB_W'(cfg_data);
				cba_pkg::REG_MINIMAL_CHUNKS: minc_q <= cba_pkg::MINC_W'(cfg_data);
				cba_pkg::REG_SLOT_SIZE:      es_q   <= cfg_data;
				default: begin
					cb_q <= cb_q;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			total_q <= '0;
		end else if (cfg_we && cfg_index <= cba_pkg::REG_SLOT_SIZE) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						total_q <= eff_min;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						func_q <= req.func;
						st_q   <= cba_pkg::ST_OK;
						nh_q   <= '0;
						ci_q   <= '0;
						off_q  <= '0;
						c_q    <= '0;
						b_q    <= '0;
						base_q <= '0;
						rem_q  <= RW'(idx >> 3);
						k_q    <= idx[2:0];
						priority case (req.func)
							cba_pkg::FUNC_ALLOC: state_q <= S_ARD;
							cba_pkg::FUNC_FREE, cba_pkg::FUNC_LOOKUP: begin
								if (req.handle == '0) begin
									st_q    <= cba_pkg::ST_INVALID;
									state_q <= S_FIN;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (mem_rdata != cba_pkg::BYTE_FULL) begin
						nh_q    <= cba_pkg::HANDLE_W'(32'(base_q) + 32'(zero_k) + 1);
						state_q <= S_FIN;
					end else if (last_b && last_c) begin
						if (32'(total_q) >= MAX_CHUNKS) begin
							st_q <= cba_pkg::ST_NOSPACE;
						end else begin
							nh_q    <= cba_pkg::HANDLE_W'(32'(base_q) + 9);
							total_q <= total_q + NW'(1);
						end
						state_q <= S_FIN;
					end else begin
						base_q <= base_q + SW'(8);
						if (last_b) begin
							b_q <= '0;
							c_q <= c_q + CW'(1);
						end else begin
							b_q <= b_q + BW'(1);
						end
						state_q <= S_ARD;
					end
				end
				// handle split by repeated subtraction of the chunk size
				S_DIV: begin
					if (32'(rem_q) < 32'(bpc)) begin
						state_q <= S_HRD;
					end else if (last_c) begin
						st_q    <= cba_pkg::ST_INVALID;
						state_q <= S_FIN;
					end else begin
						rem_q <= rem_q - RW'(bpc);
						c_q   <= c_q + CW'(1);
					end
				end
				S_HRD: state_q <= S_HCHK;
				S_HCHK: begin
					if (func_q == cba_pkg::FUNC_FREE) begin
						state_q <= S_TST;
					end else begin
						if (slot_free) begin
							st_q <= cba_pkg::ST_NOTALLOC;
						end else begin
							ci_q  <= c_q;
							off_q <= cba_pkg::OFFS_W'({BW'(rem_q), k_q}) *
								cba_pkg::OFFS_W'(es_q);
						end
						state_q <= S_FIN;
					end
				end
				// drop empty chunks from the top
				S_TST: begin
					b_q <= '0;
					if (total_q > eff_min) begin
						state_q <= S_TRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_TRD: state_q <= S_TCHK;
				S_TCHK: begin
					if (mem_rdata != 8'd0) begin
						state_q <= S_FIN;
					end else if (last_b) begin
						total_q <= total_q - NW'(1);
						state_q <= S_TST;
					end else begin
						b_q     <= b_q + BW'(1);
						state_q <= S_TRD;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			rsp_status_q <= st_q;
			rsp_nh_q     <= nh_q;
			rsp_ci_q     <= cba_pkg::CIDX_W'(ci_q);
			rsp_off_q    <= off_q;
			rsp_act_q    <= cba_pkg::ACTIVE_W'(total_q);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.new_handle    = rsp_nh_q;
	assign rsp.chunk_num     = rsp_ci_q;
	assign rsp.byte_offset   = rsp_off_q;
	assign rsp.active_chunks = rsp_act_q;

endmodule

// File: design/cba_bitmap_ram.sv
// Single-port bit map store, one byte per entry, registered read data.
// No dependencies.
module cba_bitmap_ram #(
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [0:(1<<AW)-1];

	// write, and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the chunked bitmap slot allocator.
// Depends on cba_pkg, the cba_req_if/cba_rsp_if interfaces and the block.
// A scoreboard class predicts each response word; plain tasks drive the ports.
module testbench;
	import cba_pkg::*;

	localparam int NCHUNK = 64;
	localparam int NBYTE  = 32;
	localparam int STALL_LIMIT = 30000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] new_handle;
		logic [CIDX_W-1:0]   chunk_num;
		logic [OFFS_W-1:0]   byte_offset;
		logic [ACTIVE_W-1:0] active_chunks;
	} rsp_word_t;

	// slot map predictor and queue of expected response words
	class slot_scoreboard;
		bit [7:0] slot_map [NCHUNK*NBYTE];
		int unsigned chunk_total, chunk_bytes, minimal_chunks, slot_size;
		rsp_word_t owed_q [$];
		int errors;

		function int unsigned bytes_per_chunk();
			if (chunk_bytes == 0) return 1;
			if (chunk_bytes > NBYTE) return NBYTE;
			return chunk_bytes;
		endfunction

		function int unsigned min_chunks();
			if (minimal_chunks == 0) return 1;
			if (minimal_chunks > NCHUNK) return NCHUNK;
			return minimal_chunks;
		endfunction

		function void clear_map();
			foreach (slot_map[i]) slot_map[i] = '0;
			chunk_total = min_chunks();
		endfunction

		function void reset_regs();
			chunk_bytes = CHUNK_BYTES_RST;
			minimal_chunks = MIN_CHUNKS_RST;
			slot_size = ESIZE_RST;
			errors = 0;
			clear_map();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CHUNK_BYTES: chunk_bytes = val[CB_W-1:0];
				REG_MINIMAL_CHUNKS: minimal_chunks = val[MINC_W-1:0];
				REG_SLOT_SIZE: slot_size = val[ESIZE_W-1:0];
				default: return;
			endcase
			clear_map();
		endfunction

		function bit chunk_empty(int unsigned c, int unsigned bpc);
			for (int unsigned b = 0; b < bpc; b++)
				if (slot_map[c*bpc+b] != 0) return 0;
			return 1;
		endfunction

		// a handle in range, mostly one whose slot is taken
		function logic [HANDLE_W-1:0] pick_used();
			int unsigned span, start, idx, bpc;
			bpc = bytes_per_chunk();
			span = bpc * 8 * chunk_total;
			start = $urandom_range(span - 1);
			for (int unsigned n = 0; n < span; n++) begin
				idx = (start + n) % span;
				if (slot_map[(idx/(bpc*8))*bpc + (idx%(bpc*8))/8][idx%8])
					return HANDLE_W'(idx + 1);
			end
			return HANDLE_W'(start + 1);
		endfunction

		// predict the response word of an accepted request
		function void note(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle);
			rsp_word_t w;
			int unsigned bpc, spc, idx, c, s, pos, k;
			bit found;
			bpc = bytes_per_chunk();
			spc = bpc * 8;
			w = '0;
			w.status = ST_OK;
			found = 0;
			if (func == FUNC_ALLOC) begin
				for (c = 0; c < chunk_total && !found; c++)
					for (int unsigned b = 0; b < bpc && !found; b++)
						if (slot_map[c*bpc+b] != BYTE_FULL) begin
							for (k = 0; k < 8; k++)
								if (!slot_map[c*bpc+b][k]) break;
							slot_map[c*bpc+b][k] = 1'b1;
							w.new_handle = HANDLE_W'(c*spc + b*8 + k + 1);
							found = 1;
						end
				if (!found) begin
					if (chunk_total >= NCHUNK) begin
						w.status = ST_NOSPACE;
					end else begin
						c = chunk_total;
						for (int unsigned b = 0; b < bpc; b++) slot_map[c*bpc+b] = '0;
						slot_map[c*bpc] = 8'd1;
						chunk_total = c + 1;
						w.new_handle = HANDLE_W'(c*spc + 1);
					end
				end
			end else if (func == FUNC_FREE || func == FUNC_LOOKUP) begin
				if (handle == 0 || handle - 1 >= spc * chunk_total) begin
					w.status = ST_INVALID;
				end else begin
					idx = handle - 1;
					c = idx / spc;
					s = idx % spc;
					pos = c*bpc + s/8;
					if (func == FUNC_FREE) begin
						slot_map[pos][s%8] = 1'b0;
						while (chunk_total > min_chunks() && chunk_empty(chunk_total-1, bpc))
							chunk_total--;
					end else if (slot_map[pos][s%8]) begin
						w.chunk_num = CIDX_W'(c);
						w.byte_offset = OFFS_W'(s * slot_size);
					end else begin
						w.status = ST_NOTALLOC;
					end
				end
			end
			w.active_chunks = ACTIVE_W'(chunk_total);
			owed_q.push_back(w);
		endfunction

		// compare a response word with the oldest prediction
		function void check(rsp_word_t got);
			rsp_word_t exp_w;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected response word %p", $realtime, got);
				errors++;
				return;
			end
			exp_w = owed_q.pop_front();
			if (got.status !== exp_w.status)
				$display("%0t: status exp %0d got %0d", $realtime, exp_w.status, got.status);
			if (got.new_handle !== exp_w.new_handle)
				$display("%0t: new_handle exp %0d got %0d", $realtime,
					exp_w.new_handle, got.new_handle);
			if (got.chunk_num !== exp_w.chunk_num)
				$display("%0t: chunk_num exp %0d got %0d", $realtime,
					exp_w.chunk_num, got.chunk_num);
			if (got.byte_offset !== exp_w.byte_offset)
				$display("%0t: byte_offset exp %0d got %0d", $realtime,
					exp_w.byte_offset, got.byte_offset);
			if (got.active_chunks !== exp_w.active_chunks)
				$display("%0t: active_chunks exp %0d got %0d", $realtime,
					exp_w.active_chunks, got.active_chunks);
			if (got !== exp_w) errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit calm;
	int quiet_cycles;
	slot_scoreboard sb;

	cba_req_if req ();
	cba_rsp_if rsp ();

	chunked_bitmap_slot_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side: random stalls, check every accepted word
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check({rsp.status, rsp.new_handle, rsp.chunk_num, rsp.byte_offset,
				rsp.active_chunks});
		rsp.ready <= calm || ($urandom_range(99) >= 9);
	end

	// watchdog on cycles with no word moved on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// present one request word and hold it until taken
	task automatic send(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle);
		if (!calm && $urandom_range(99) < 9) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 30) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.handle <= handle;
		do @(posedge clk); while (!req.ready);
		sb.note(func, handle);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write all three registers while the block is idle
	task automatic set_config(int unsigned cb, int unsigned mc, int unsigned es);
		logic [CFG_DATA_W-1:0] vals [3];
		logic [CFG_IDX_W-1:0] regs [3];
		vals = '{CFG_DATA_W'(cb), CFG_DATA_W'(mc), CFG_DATA_W'(es)};
		regs = '{REG_CHUNK_BYTES, REG_MINIMAL_CHUNKS, REG_SLOT_SIZE};
		drain();
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// mixed traffic: mostly alloc/free/lookup of live slots, some noise
	task automatic random_traffic(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 45) send(FUNC_ALLOC, '0);
			else if (r < 75) send(FUNC_FREE, sb.pick_used());
			else if (r < 90) send(FUNC_LOOKUP, sb.pick_used());
			else send(FUNC_W'($urandom_range(3)), HANDLE_W'($urandom_range(32767)));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		calm = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.func = FUNC_ALLOC;
		req.handle = '0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at reset settings
		send(FUNC_LOOKUP, '0);
		send(FUNC_FREE, '0);
		send(FUNC_LOOKUP, 15'h7FFF);
		send(FUNC_FREE, 15'd129);
		send(FUNC_LOOKUP, 15'd128);
		for (int i = 0; i < 4; i++) send(FUNC_ALLOC, '0);
		send(FUNC_LOOKUP, 15'd3);
		send(FUNC_FREE, 15'd2);
		send(FUNC_FREE, 15'd2);
		send(FUNC_LOOKUP, 15'd2);
		send(FUNC_ALLOC, '0);
		send(FUNC_UNUSED, 15'd5);
		send(FUNC_LOOKUP, 15'd100);

		// one-byte chunks, minimum one chunk: fill up to the chunk limit
		set_config(0, 0, 0);
		for (int i = 0; i < 515; i++) send(FUNC_ALLOC, '0);
		send(FUNC_LOOKUP, 15'd512);
		send(FUNC_FREE, 15'd512);
		send(FUNC_FREE, 15'd511);
		random_traffic(60);

		// largest chunks, top minimum, largest slot size
		set_config(63, 127, 16'hFFFF);
		send(FUNC_LOOKUP, 15'd16384);
		send(FUNC_FREE, 15'd16384);
		send(FUNC_LOOKUP, 15'd16385);
		random_traffic(110);

		// no idling on either side through this setting
		set_config(2, 2, $urandom_range(1, 65535));
		calm = 1'b1;
		random_traffic(150);
		calm = 1'b0;

		set_config(32, 100, $urandom_range(65535));
		random_traffic(100);
		set_config(1, 64, 255);
		random_traffic(100);
		set_config($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(65535));
		random_traffic(110);

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.owed_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

// File: files.f
design/cba_pkg.sv
design/cba_ifs.sv
design/cba_bitmap_ram.sv
design/chunked_bitmap_slot_allocator.sv
tb/testbench.sv
